### rtl/core/wfd_pkg.sv
package wfd_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_MSG_BYTE  = 3'd0;
    localparam logic [2:0] KIND_PONG_BYTE = 3'd1;
    localparam logic [2:0] KIND_COMMIT    = 3'd2;
    localparam logic [2:0] KIND_DISCARD   = 3'd3;
    localparam logic [2:0] KIND_PONG_SEND = 3'd4;
    localparam logic [2:0] KIND_CLOSE     = 3'd5;

    // Close codes.
    localparam logic [9:0] CLOSE_NORMAL      = 10'd1000;
    localparam logic [9:0] CLOSE_PROTOCOL    = 10'd1002;
    localparam logic [9:0] CLOSE_UNSUPPORTED = 10'd1003;
    localparam logic [9:0] CLOSE_TOO_BIG     = 10'd1009;

    // Frame opcodes.
    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_BIN  = 4'h2;
    localparam logic [3:0] OP_CLS  = 4'h8;
    localparam logic [3:0] OP_PING = 4'h9;

    // Header length codes.
    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;

    localparam logic [12:0] MAX_LEN_RESET = 13'd4096;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [11:0] position;
        logic [12:0] length;
        logic [9:0]  close_code;
        logic        last;
    } t_result;

    function automatic t_result make_result(
        input logic [2:0]  kind,
        input logic [7:0]  data_byte,
        input logic [11:0] position,
        input logic [12:0] length,
        input logic [9:0]  close_code
    );
        t_result r;
        r.kind       = kind;
        r.data_byte  = data_byte;
        r.position   = position;
        r.length     = length;
        r.close_code = close_code;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

### rtl/core/websocket_frame_deframer_core.sv
// A result item is written into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while o_in_ready is high; a byte may push two result items.
// The 4-entry result queue sets the rate: input ready drops with fewer than two free slots.
// Reset (synchronous, active low) clears the parser state, the halt flag and the queue,
// and sets the length limit register to 4096.
module websocket_frame_deframer_core #(
    parameter int unsigned MAX_MESSAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_max_message_len,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [11:0] o_position,
    output logic [12:0] o_length,
    output logic [9:0]  o_close_code,
    output logic        o_last
);
    import wfd_pkg::*;

    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    // Configuration and parser state.
    logic [12:0] r_max_len;
    logic        r_in_payload,   n_in_payload;
    logic [3:0]  r_header_pos,   n_header_pos;
    logic [2:0]  r_ext_len,      n_ext_len;
    logic [31:0] r_frame_len,    n_frame_len;
    logic        r_fin,          n_fin;
    logic [3:0]  r_opcode,       n_opcode;
    logic [31:0] r_mask_key,     n_mask_key;
    logic [12:0] r_payload_cnt,  n_payload_cnt;
    logic        r_reasm_open,   n_reasm_open;
    logic [12:0] r_reasm_len,    n_reasm_len;
    logic        r_overflow,     n_overflow;
    logic        r_halted,       n_halted;

    // Result queue.
    t_result          r_queue [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QAW:0]     r_count;

    logic        in_fire, out_fire;
    logic [12:0] limit;
    t_result     push_res [2];
    logic [1:0]  push_cnt;
    logic        do_end;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic [13:0] msg_pos;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = r_count <= (QAW+1)'(QDEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    assign o_kind       = r_queue[r_rd_ptr].kind;
    assign o_data_byte  = r_queue[r_rd_ptr].data_byte;
    assign o_position   = r_queue[r_rd_ptr].position;
    assign o_length     = r_queue[r_rd_ptr].length;
    assign o_close_code = r_queue[r_rd_ptr].close_code;
    assign o_last       = r_queue[r_rd_ptr].last;

    // The register value is saturated to the build-time maximum.
    always_comb begin
        if ({19'd0, r_max_len} > 32'(MAX_MESSAGE_BYTES)) begin
            limit = 13'(MAX_MESSAGE_BYTES);
        end else begin
            limit = r_max_len;
        end
    end

    always_comb begin
        unique case (r_payload_cnt[1:0])
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    assign plain   = i_rx_byte ^ key_byte;
    assign msg_pos = {1'b0, r_reasm_len} + {1'b0, r_payload_cnt};

    always_comb begin
        n_in_payload  = r_in_payload;
        n_header_pos  = r_header_pos;
        n_ext_len     = r_ext_len;
        n_frame_len   = r_frame_len;
        n_fin         = r_fin;
        n_opcode      = r_opcode;
        n_mask_key    = r_mask_key;
        n_payload_cnt = r_payload_cnt;
        n_reasm_open  = r_reasm_open;
        n_reasm_len   = r_reasm_len;
        n_overflow    = r_overflow;
        n_halted      = r_halted;
        push_res[0]   = make_result(KIND_MSG_BYTE, 8'd0, 12'd0, 13'd0, 10'd0);
        push_res[1]   = push_res[0];
        push_cnt      = 2'd0;
        do_end        = 1'b0;

        if (in_fire && !r_halted) begin
            if (r_in_payload) begin
                if (r_opcode == OP_BIN || (r_opcode == OP_CONT && r_reasm_open)) begin
                    if (r_overflow || msg_pos >= {1'b0, limit}) begin
                        n_overflow = 1'b1;
                    end else begin
                        push_res[push_cnt[0]] = make_result(KIND_MSG_BYTE, plain,
                                                            msg_pos[11:0], 13'd0, 10'd0);
                        push_cnt = push_cnt + 2'd1;
                    end
                end else if (r_opcode == OP_PING) begin
                    push_res[push_cnt[0]] = make_result(KIND_PONG_BYTE, plain,
                                                        r_payload_cnt[11:0], 13'd0, 10'd0);
                    push_cnt = push_cnt + 2'd1;
                end
                n_payload_cnt = r_payload_cnt + 13'd1;
                if ({19'd0, n_payload_cnt} >= r_frame_len) begin
                    do_end = 1'b1;
                end
            end else begin
                priority if (r_header_pos == 4'd0) begin
                    n_fin    = i_rx_byte[7];
                    n_opcode = i_rx_byte[3:0];
                    if (i_rx_byte[6:4] != 3'd0 || i_rx_byte[2:0] > 3'd2) begin
                        push_res[push_cnt[0]] = make_result(KIND_CLOSE, 8'd0, 12'd0, 13'd0,
                                                            CLOSE_PROTOCOL);
                        push_cnt = push_cnt + 2'd1;
                        n_halted = 1'b1;
                    end
                end else if (r_header_pos == 4'd1) begin
                    if (!i_rx_byte[7]) begin
                        push_res[push_cnt[0]] = make_result(KIND_CLOSE, 8'd0, 12'd0, 13'd0,
                                                            CLOSE_PROTOCOL);
                        push_cnt = push_cnt + 2'd1;
                        n_halted = 1'b1;
                    end else if (i_rx_byte[6:0] <= LEN_MAX_SHORT) begin
                        n_ext_len   = 3'd0;
                        n_frame_len = {25'd0, i_rx_byte[6:0]};
                    end else if (i_rx_byte[6:0] == LEN_EXT16) begin
                        n_ext_len   = 3'd2;
                        n_frame_len = 32'd0;
                    end else begin
                        n_ext_len   = 3'd4;
                        n_frame_len = 32'd0;
                    end
                end else if (r_header_pos < 4'd2 + {1'b0, r_ext_len}) begin
                    n_frame_len = {r_frame_len[23:0], i_rx_byte};
                end else begin
                    n_mask_key = {r_mask_key[23:0], i_rx_byte};
                end

                if (!n_halted) begin
                    n_header_pos = r_header_pos + 4'd1;
                    if (n_header_pos == 4'd6 + {1'b0, n_ext_len}) begin
                        n_header_pos = 4'd0;
                        if (n_frame_len > {19'd0, limit}) begin
                            push_res[push_cnt[0]] = make_result(KIND_CLOSE, 8'd0, 12'd0,
                                                                13'd0, CLOSE_TOO_BIG);
                            push_cnt = push_cnt + 2'd1;
                            n_halted = 1'b1;
                        end else begin
                            n_payload_cnt = 13'd0;
                            if (n_opcode == OP_BIN) begin
                                // A new message drops any message still being assembled.
                                if (r_reasm_open) begin
                                    push_res[push_cnt[0]] = make_result(KIND_DISCARD, 8'd0,
                                                                        12'd0, 13'd0, 10'd0);
                                    push_cnt = push_cnt + 2'd1;
                                end
                                n_reasm_open = 1'b1;
                                n_reasm_len  = 13'd0;
                                n_overflow   = 1'b0;
                            end
                            if (n_frame_len == 32'd0) begin
                                do_end = 1'b1;
                            end else begin
                                n_in_payload = 1'b1;
                            end
                        end
                    end
                end
            end

            if (do_end) begin
                n_in_payload = 1'b0;
                n_header_pos = 4'd0;
                unique case (n_opcode)
                    OP_CONT, OP_BIN: begin
                        if (n_opcode == OP_CONT && !n_reasm_open) begin
                            push_res[push_cnt[0]] = make_result(KIND_CLOSE, 8'd0, 12'd0,
                                                                13'd0, CLOSE_PROTOCOL);
                            push_cnt = push_cnt + 2'd1;
                            n_halted = 1'b1;
                        end else if (n_overflow) begin
                            push_res[push_cnt[0]] = make_result(KIND_DISCARD, 8'd0, 12'd0,
                                                                13'd0, 10'd0);
                            push_cnt = push_cnt + 2'd1;
                            n_reasm_open = 1'b0;
                            n_reasm_len  = 13'd0;
                            n_overflow   = 1'b0;
                        end else begin
                            n_reasm_len = n_reasm_len + n_frame_len[12:0];
                            if (n_fin) begin
                                // An empty message is dropped without a commit.
                                if (n_reasm_len != 13'd0) begin
                                    push_res[push_cnt[0]] = make_result(KIND_COMMIT, 8'd0,
                                                                        12'd0, n_reasm_len,
                                                                        10'd0);
                                    push_cnt = push_cnt + 2'd1;
                                end
                                n_reasm_open = 1'b0;
                                n_reasm_len  = 13'd0;
                                n_overflow   = 1'b0;
                            end
                        end
                    end
                    OP_TEXT: begin
                        push_res[push_cnt[0]] = make_result(KIND_CLOSE, 8'd0, 12'd0, 13'd0,
                                                            CLOSE_UNSUPPORTED);
                        push_cnt = push_cnt + 2'd1;
                        n_halted = 1'b1;
                    end
                    OP_CLS: begin
                        push_res[push_cnt[0]] = make_result(KIND_CLOSE, 8'd0, 12'd0, 13'd0,
                                                            CLOSE_NORMAL);
                        push_cnt = push_cnt + 2'd1;
                        n_halted = 1'b1;
                    end
                    OP_PING: begin
                        push_res[push_cnt[0]] = make_result(KIND_PONG_SEND, 8'd0, 12'd0,
                                                            n_frame_len[12:0], 10'd0);
                        push_cnt = push_cnt + 2'd1;
                    end
                    default: begin
                    end
                endcase
            end

            if (push_cnt == 2'd1) begin
                push_res[0].last = 1'b1;
            end else if (push_cnt == 2'd2) begin
                push_res[1].last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len     <= MAX_LEN_RESET;
            r_in_payload  <= 1'b0;
            r_header_pos  <= 4'd0;
            r_ext_len     <= 3'd0;
            r_frame_len   <= 32'd0;
            r_fin         <= 1'b0;
            r_opcode      <= 4'd0;
            r_mask_key    <= 32'd0;
            r_payload_cnt <= 13'd0;
            r_reasm_open  <= 1'b0;
            r_reasm_len   <= 13'd0;
            r_overflow    <= 1'b0;
            r_halted      <= 1'b0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_len <= i_max_message_len;
            end
            r_in_payload  <= n_in_payload;
            r_header_pos  <= n_header_pos;
            r_ext_len     <= n_ext_len;
            r_frame_len   <= n_frame_len;
            r_fin         <= n_fin;
            r_opcode      <= n_opcode;
            r_mask_key    <= n_mask_key;
            r_payload_cnt <= n_payload_cnt;
            r_reasm_open  <= n_reasm_open;
            r_reasm_len   <= n_reasm_len;
            r_overflow    <= n_overflow;
            r_halted      <= n_halted;
            r_wr_ptr      <= r_wr_ptr + QAW'(push_cnt);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QAW+1)'(push_cnt) - (QAW+1)'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= push_res[0];
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + 1'b1] <= push_res[1];
        end
    end

endmodule

### rtl/core/wfd_checker.sv
module wfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic [9:0]  o_close_code,
    input logic        o_last
);
    import wfd_pkg::*;

    // A result waiting on the output holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_close_code) && $stable(o_last))
        else $error("output item changed while stalled");

    // Only payload byte items carry data.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_MSG_BYTE && o_kind != KIND_PONG_BYTE
            |-> o_data_byte == 8'd0)
        else $error("data on a non-byte item");

    // A close item carries a legal code and ends its byte's results.
    a_close_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_CLOSE
            |-> o_last && (o_close_code == CLOSE_NORMAL || o_close_code == CLOSE_PROTOCOL
                || o_close_code == CLOSE_UNSUPPORTED || o_close_code == CLOSE_TOO_BIG))
        else $error("bad close item");

    // Nothing follows a close until reset.
    a_close_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_kind == KIND_CLOSE |=> !o_out_valid)
        else $error("item after close");

endmodule

bind websocket_frame_deframer_core wfd_checker u_wfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_data_byte  (o_data_byte),
    .o_close_code (o_close_code),
    .o_last       (o_last)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wfd_pkg::*;

    localparam int          MSG_BYTES   = 4096;
    localparam logic [12:0] MSG_CAP     = 13'(MSG_BYTES);
    localparam int          CYCLE_LIMIT = 1000000;

    // The pong opcode and the 32-bit length code are not in the package.
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [6:0] LEN_EXT32 = 7'd127;

    // Length encodings for generated headers.
    localparam int ENC_SHORT = 0;
    localparam int ENC_EXT16 = 1;
    localparam int ENC_EXT32 = 2;

    // Ways to end the stream with a close.
    localparam int FAULT_RSV         = 0;
    localparam int FAULT_OPCODE      = 1;
    localparam int FAULT_NOMASK      = 2;
    localparam int FAULT_OVERSIZE    = 3;
    localparam int FAULT_ORPHAN_CONT = 4;
    localparam int FAULT_TEXT        = 5;
    localparam int FAULT_CLOSE       = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [12:0] i_max_message_len;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [11:0] o_position;
    logic [12:0] o_length;
    logic [9:0]  o_close_code;
    logic        o_last;

    websocket_frame_deframer_core #(
        .MAX_MESSAGE_BYTES(MSG_BYTES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_max_message_len(i_max_message_len),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_position       (o_position),
        .o_length         (o_length),
        .o_close_code     (o_close_code),
        .o_last           (o_last)
    );

    // Deframer state as predicted from the accepted bytes.
    logic        in_body;
    logic [3:0]  hdr_idx;
    logic [2:0]  ext_bytes;
    logic [31:0] frm_len;
    logic        frm_fin;
    logic [3:0]  frm_op;
    logic [31:0] mask_word;
    logic [12:0] body_idx;
    logic        msg_open;
    logic [12:0] msg_len;
    logic        msg_over;
    logic        stopped;
    logic [12:0] cap_reg;

    t_result step_events[$];
    t_result awaited_events[$];

    int  mismatches;
    int  bytes_sent;
    int  rx_hold_len;
    bit  no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] w;
        w = $urandom;
        return w[7:0];
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic logic [12:0] len_cap();
        return (cap_reg > MSG_CAP) ? MSG_CAP : cap_reg;
    endfunction

    function automatic void emit_event(input logic [2:0] kind, input logic [7:0] d,
                                       input logic [11:0] pos, input logic [12:0] len,
                                       input logic [9:0] code);
        t_result r;
        r.kind       = kind;
        r.data_byte  = d;
        r.position   = pos;
        r.length     = len;
        r.close_code = code;
        r.last       = 1'b0;
        step_events.push_back(r);
    endfunction

    function automatic void shut_down(input logic [9:0] code);
        emit_event(KIND_CLOSE, 8'd0, 12'd0, 13'd0, code);
        stopped = 1'b1;
    endfunction

    function automatic void drop_message();
        msg_open = 1'b0;
        msg_len  = 13'd0;
        msg_over = 1'b0;
    endfunction

    function automatic void finish_frame();
        in_body = 1'b0;
        hdr_idx = 4'd0;
        case (frm_op)
            OP_CONT, OP_BIN: begin
                if (frm_op == OP_CONT && !msg_open) begin
                    shut_down(CLOSE_PROTOCOL);
                end else if (msg_over) begin
                    emit_event(KIND_DISCARD, 8'd0, 12'd0, 13'd0, 10'd0);
                    drop_message();
                end else begin
                    msg_len = msg_len + frm_len[12:0];
                    if (frm_fin) begin
                        // A message that ends up empty is dropped without a commit.
                        if (msg_len != 13'd0) begin
                            emit_event(KIND_COMMIT, 8'd0, 12'd0, msg_len, 10'd0);
                        end
                        drop_message();
                    end
                end
            end
            OP_TEXT:  shut_down(CLOSE_UNSUPPORTED);
            OP_CLS:   shut_down(CLOSE_NORMAL);
            OP_PING:  emit_event(KIND_PONG_SEND, 8'd0, 12'd0, frm_len[12:0], 10'd0);
            default: ;
        endcase
    endfunction

    function automatic void header_step(input logic [7:0] c);
        if (hdr_idx == 4'd0) begin
            frm_fin = c[7];
            frm_op  = c[3:0];
            if (c[6:4] != 3'd0 || c[2:0] > 3'd2) begin
                shut_down(CLOSE_PROTOCOL);
                return;
            end
        end else if (hdr_idx == 4'd1) begin
            if (!c[7]) begin
                shut_down(CLOSE_PROTOCOL);
                return;
            end
            if (c[6:0] <= LEN_MAX_SHORT) begin
                ext_bytes = 3'd0;
                frm_len   = {25'd0, c[6:0]};
            end else if (c[6:0] == LEN_EXT16) begin
                ext_bytes = 3'd2;
                frm_len   = 32'd0;
            end else begin
                ext_bytes = 3'd4;
                frm_len   = 32'd0;
            end
        end else if (hdr_idx < 2 + ext_bytes) begin
            frm_len = {frm_len[23:0], c};
        end else begin
            mask_word = {mask_word[23:0], c};
        end
        hdr_idx = hdr_idx + 4'd1;

        if (hdr_idx == 6 + ext_bytes) begin
            hdr_idx = 4'd0;
            if (frm_len > len_cap()) begin
                shut_down(CLOSE_TOO_BIG);
                return;
            end
            body_idx = 13'd0;
            if (frm_op == OP_BIN) begin
                // A new binary frame throws away any message still being built.
                if (msg_open) begin
                    emit_event(KIND_DISCARD, 8'd0, 12'd0, 13'd0, 10'd0);
                end
                drop_message();
                msg_open = 1'b1;
            end
            if (frm_len == 32'd0) begin
                finish_frame();
            end else begin
                in_body = 1'b1;
            end
        end
    endfunction

    function automatic void body_step(input logic [7:0] c);
        logic [7:0] d;
        int         pos;
        d = c ^ mask_word[8 * (3 - body_idx[1:0]) +: 8];
        if (frm_op == OP_BIN || (frm_op == OP_CONT && msg_open)) begin
            pos = int'(msg_len) + int'(body_idx);
            if (msg_over || pos >= len_cap()) begin
                msg_over = 1'b1;
            end else begin
                emit_event(KIND_MSG_BYTE, d, pos[11:0], 13'd0, 10'd0);
            end
        end else if (frm_op == OP_PING) begin
            emit_event(KIND_PONG_BYTE, d, body_idx[11:0], 13'd0, 10'd0);
        end
        body_idx = body_idx + 13'd1;
        if (body_idx >= frm_len) begin
            finish_frame();
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] c);
        t_result r;
        step_events.delete();
        if (stopped) begin
            return;
        end
        if (in_body) begin
            body_step(c);
        end else begin
            header_step(c);
        end
        for (int i = 0; i < step_events.size(); i++) begin
            r      = step_events[i];
            r.last = (i == step_events.size() - 1);
            awaited_events.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the input off until every predicted result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_len_limit(input logic [12:0] v);
        drain_results();
        i_cfg_valid       <= 1'b1;
        i_max_message_len <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_reg = v;
    endtask

    task automatic send_header(input logic fin, input logic [3:0] op, input int len,
                               input int enc);
        logic [31:0] key;
        logic [31:0] n;
        key = $urandom;
        n   = len;
        if (enc == ENC_SHORT && len > LEN_MAX_SHORT) begin
            enc = ENC_EXT16;
        end
        send_byte({fin, 3'b000, op});
        // The mask bit is always set on well-formed client frames.
        if (enc == ENC_SHORT) begin
            send_byte({1'b1, n[6:0]});
        end else if (enc == ENC_EXT16) begin
            send_byte({1'b1, LEN_EXT16});
            send_byte(n[15:8]);
            send_byte(n[7:0]);
        end else begin
            send_byte({1'b1, LEN_EXT32});
            for (int i = 3; i >= 0; i--) send_byte(n[8 * i +: 8]);
        end
        for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input int len,
                              input int enc, input int pause_at);
        send_header(fin, op, len, enc);
        for (int i = 0; i < len; i++) begin
            if (i == pause_at) begin
                drain_results();
            end
            send_byte(rand_byte());
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_mixed_frames();
        write_len_limit(13'h1fff);
        send_frame(1'b1, OP_BIN, 0, ENC_SHORT, -1);
        send_frame(1'b1, OP_BIN, 3, ENC_SHORT, -1);
        send_frame(1'b0, OP_BIN, 2, ENC_EXT16, -1);
        send_frame(1'b1, OP_PING, 2, ENC_SHORT, -1);
        send_frame(1'b1, OP_PONG, 1, ENC_SHORT, -1);
        send_frame(1'b1, OP_CONT, 5, ENC_EXT32, -1);
        send_frame(1'b0, OP_BIN, 1, ENC_SHORT, -1);
        send_frame(1'b1, OP_BIN, 1, ENC_SHORT, -1);
        send_frame(1'b1, OP_PING, 0, ENC_EXT16, -1);
        send_frame(1'b1, OP_BIN, 125, ENC_SHORT, -1);
    endtask

    task automatic test_tiny_limit();
        write_len_limit(13'd1);
        send_frame(1'b1, OP_BIN, 1, ENC_SHORT, -1);
        send_frame(1'b0, OP_BIN, 1, ENC_SHORT, -1);
        send_frame(1'b1, OP_CONT, 1, ENC_SHORT, -1);
        send_frame(1'b1, OP_BIN, 0, ENC_SHORT, -1);
        send_frame(1'b1, OP_PING, 1, ENC_EXT32, -1);
        send_frame(1'b0, OP_BIN, 1, ENC_SHORT, -1);
        send_frame(1'b0, OP_CONT, 0, ENC_SHORT, -1);
        send_frame(1'b1, OP_CONT, 0, ENC_EXT16, -1);
    endtask

    // The receiver stalls long enough for the result queue to fill and block input.
    task automatic test_backpressure();
        write_len_limit(MSG_CAP);
        no_gaps     = 1'b1;
        rx_hold_len = 150;
        send_frame(1'b1, OP_PING, 48, ENC_SHORT, -1);
        send_frame(1'b1, OP_BIN, 30, ENC_EXT16, -1);
        no_gaps = 1'b0;
        drain_results();
    endtask

    task automatic test_sender_pause();
        send_frame(1'b0, OP_BIN, 20, ENC_SHORT, 9);
        send_frame(1'b1, OP_CONT, 10, ENC_EXT16, 0);
    endtask

    task automatic send_random_frame();
        int         r;
        int         top;
        int         len;
        int         enc;
        logic       fin;
        logic [3:0] op;
        no_gaps = ($urandom_range(0, 4) == 0);
        fin     = 1'($urandom_range(0, 1));
        r       = $urandom_range(0, 99);
        if (r < 40) begin
            op = msg_open ? OP_CONT : OP_BIN;
        end else if (r < 65) begin
            op = OP_BIN;
        end else if (r < 82) begin
            op = OP_PING;
        end else if (r < 90) begin
            op = OP_PONG;
        end else begin
            op  = msg_open ? OP_CONT : OP_BIN;
            fin = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            top = 0;
        end else if (r < 75) begin
            top = 12;
        end else if (r < 95) begin
            top = 60;
        end else begin
            top = 300;
        end
        if (top > len_cap()) begin
            top = int'(len_cap());
        end
        len = ($urandom_range(0, 9) == 0) ? top : $urandom_range(0, top);
        r   = $urandom_range(0, 99);
        if (len > LEN_MAX_SHORT || r >= 70) begin
            enc = (r % 2 == 0) ? ENC_EXT16 : ENC_EXT32;
        end else begin
            enc = ENC_SHORT;
        end
        send_frame(fin, op, len, enc, -1);
    endtask

    task automatic test_random_traffic();
        int          mode;
        int          stop_at;
        logic [12:0] lim;
        for (int phase = 0; phase < 6; phase++) begin
            mode = (phase < 5) ? phase : $urandom_range(0, 4);
            case (mode)
                0:       lim = 13'($urandom_range(1, 8));
                1:       lim = 13'($urandom_range(9, 200));
                2:       lim = 13'($urandom_range(201, MSG_BYTES - 1));
                3:       lim = MSG_CAP;
                default: lim = 13'($urandom_range(MSG_BYTES + 1, 8191));
            endcase
            write_len_limit(lim);
            stop_at = bytes_sent + 70;
            while (bytes_sent < stop_at) send_random_frame();
        end
        no_gaps = 1'b0;
    endtask

    // Only one close is possible per run, since reset is never repeated.
    task automatic test_close_and_halt();
        int         fault;
        int         len;
        logic [2:0] rsv;
        logic [3:0] bad_op;
        logic [7:0] junk;
        write_len_limit(13'($urandom_range(1, 8191)));
        fault = $urandom_range(FAULT_RSV, FAULT_CLOSE);
        len   = $urandom_range(0, (len_cap() < 6) ? len_cap() : 6);
        case (fault)
            FAULT_RSV: begin
                rsv = 3'($urandom_range(1, 7));
                send_byte({1'b1, rsv, OP_BIN});
            end
            FAULT_OPCODE: begin
                bad_op = {1'($urandom_range(0, 1)), 3'($urandom_range(3, 7))};
                send_byte({1'b1, 3'b000, bad_op});
            end
            FAULT_NOMASK: begin
                send_byte({1'b1, 3'b000, OP_BIN});
                junk = rand_byte();
                send_byte({1'b0, junk[6:0]});
            end
            FAULT_OVERSIZE: begin
                // Above the saturation point this checks the clamp of the register.
                if (cap_reg > MSG_CAP) begin
                    len = $urandom_range(MSG_BYTES + 1, cap_reg);
                end else begin
                    len = len_cap() + $urandom_range(1, 3000);
                end
                send_header(1'b1, OP_BIN, len, $urandom_range(ENC_EXT16, ENC_EXT32));
            end
            FAULT_ORPHAN_CONT: begin
                if (msg_open) begin
                    send_frame(1'b1, OP_BIN, 0, ENC_SHORT, -1);
                end
                send_frame(1'($urandom_range(0, 1)), OP_CONT, len, ENC_SHORT, -1);
            end
            FAULT_TEXT:  send_frame(1'b1, OP_TEXT, len, ENC_SHORT, -1);
            default:     send_frame(1'b1, OP_CLS, len, ENC_EXT16, -1);
        endcase
        // Everything after the close must be ignored.
        send_frame(1'b1, OP_PING, 3, ENC_SHORT, -1);
        for (int i = 0; i < 30; i++) send_byte(rand_byte());
    endtask

    // ---------------------------------------------------------------- processes

    initial begin : rx_pacing
        int n;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    initial begin : result_check
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (awaited_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, kind %0d code %0d",
                                              o_kind, o_close_code));
                end else begin
                    want = awaited_events.pop_front();
                    check_field("kind", 32'(o_kind), 32'(want.kind));
                    check_field("data_byte", 32'(o_data_byte), 32'(want.data_byte));
                    check_field("position", 32'(o_position), 32'(want.position));
                    check_field("length", 32'(o_length), 32'(want.length));
                    check_field("close_code", 32'(o_close_code), 32'(want.close_code));
                    check_field("last", 32'(o_last), 32'(want.last));
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL websocket_frame_deframer_core");
        $finish;
    end

    initial begin
        in_body     = 1'b0;
        hdr_idx     = 4'd0;
        ext_bytes   = 3'd0;
        frm_len     = 32'd0;
        frm_fin     = 1'b0;
        frm_op      = OP_CONT;
        mask_word   = 32'd0;
        body_idx    = 13'd0;
        msg_open    = 1'b0;
        msg_len     = 13'd0;
        msg_over    = 1'b0;
        stopped     = 1'b0;
        cap_reg     = MAX_LEN_RESET;
        mismatches  = 0;
        bytes_sent  = 0;
        rx_hold_len = 0;
        no_gaps     = 1'b0;

        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_max_message_len <= 13'd0;
        i_in_valid        <= 1'b0;
        i_rx_byte         <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mixed_frames();
        test_tiny_limit();
        test_backpressure();
        test_sender_pause();
        test_random_traffic();
        test_close_and_halt();

        drain_results();
        if (mismatches == 0) begin
            $display("PASS websocket_frame_deframer_core");
        end else begin
            $display("FAIL websocket_frame_deframer_core");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/wfd_pkg.sv
rtl/core/websocket_frame_deframer_core.sv
rtl/core/wfd_checker.sv
sim/tb_top.sv
